// ----- src/assert_macros.svh -----
// Assertion macros shared by the receive deframer modules.
// No dependencies; included by every file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Same, on the block's own clock and reset names.
`define ASSERT_SYNC(lbl, prop, msg) `ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ----- src/wsrx_pkg.sv -----
// Types and constants of the WebSocket receive deframer.
// No dependencies; imported by every module of the block but wsrx_ram.
package wsrx_pkg;

   typedef enum logic [1:0] {
      PH_OPCODE,
      PH_LENGTH,
      PH_EXTLEN,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic {
      BK_IDLE,
      BK_PONG
   } back_state_type;

   // A command from the parser: one binary payload word, or a pong with its
   // captured length in data.
   typedef struct packed {
      logic       is_pong;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   localparam logic [3:0] OPC_BINARY   = 4'h2;
   localparam logic [3:0] OPC_PING     = 4'h9;
   localparam logic [7:0] PONG_HEADER  = 8'h8A;
   localparam logic [7:0] LEN_MASK_BIT = 8'h80;
   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;
   localparam logic [3:0] EXT16_BYTES  = 4'd2;
   localparam logic [3:0] EXT64_BYTES  = 4'd8;
   localparam logic       KIND_BINARY  = 1'b0;
   localparam logic       KIND_PONG    = 1'b1;
   localparam int         PONG_HDR_BYTES = 6;
   localparam int         CMD_DEPTH    = 4;

endpackage

// ----- src/wsrx_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wsrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/wsrx_cmd_fifo.sv -----
// Short command queue between the frame parser and the output sequencer.
// Depends on wsrx_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wsrx_cmd_fifo import wsrx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   localparam int PW = $clog2(CMD_DEPTH);
   localparam int CW = $clog2(CMD_DEPTH + 1);

   cmd_type         slots_ff [CMD_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full    = (cnt_ff == CW'(CMD_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ASSERT_SYNC(a_cnt_bound, cnt_ff <= CW'(CMD_DEPTH), "command queue count out of range")
   `ASSERT_SYNC(a_cnt_grow, do_push && !do_pop |=> cnt_ff == $past(cnt_ff) + 1'b1, "queue lost a word")

endmodule

// ----- src/wsrx_front.sv -----
// Frame parser: takes one received word per cycle unless stalled, tracks the
// frame header, captures ping payload into the pong store and queues output commands.
// Depends on wsrx_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wsrx_front import wsrx_pkg::*; #(
   parameter int PONG_MAX = 16,
   localparam int AW = (PONG_MAX > 1) ? $clog2(PONG_MAX) : 1,
   localparam int CW = $clog2(PONG_MAX + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  logic [7:0]    req_rx_byte,
   output logic          req_full,
   input  logic          fifo_full,
   input  logic          pong_busy,
   output logic          cmd_push,
   output cmd_type       cmd,
   output logic          st_we,
   output logic [AW-1:0] st_addr,
   output logic [7:0]    st_data
);

   phase_type     phase_ff, phase_in;
   logic [3:0]    opcode_ff, opcode_in;
   logic [63:0]   remaining_ff, remaining_in;
   logic [3:0]    ext_left_ff, ext_left_in;
   logic [CW-1:0] count_ff, count_in;

   logic          stall, accept;
   logic          hdr_done;
   logic [63:0]   hdr_len;
   logic [63:0]   rem_dec, ext_shift;
   logic [3:0]    ext_dec;

   assign stall    = fifo_full ||
                     (pong_busy && opcode_ff == OPC_PING && phase_ff != PH_OPCODE);
   assign req_full = stall;
   assign accept   = req_push && !stall;

   assign rem_dec   = (remaining_ff != '0) ? remaining_ff - 64'd1 : remaining_ff;
   assign ext_shift = {remaining_ff[55:0], req_rx_byte};
   assign ext_dec   = (ext_left_ff != '0) ? ext_left_ff - 4'd1 : ext_left_ff;

   always_comb begin
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      remaining_in = remaining_ff;
      ext_left_in  = ext_left_ff;
      count_in     = count_ff;
      cmd_push     = 1'b0;
      cmd          = '0;
      st_we        = 1'b0;
      st_addr      = count_ff[AW-1:0];
      st_data      = req_rx_byte;
      hdr_done     = 1'b0;
      hdr_len      = '0;
      if (accept) begin
         case (phase_ff)
            PH_LENGTH: begin
               remaining_in = '0;
               if (req_rx_byte[6:0] == LEN_EXT16) begin
                  ext_left_in = EXT16_BYTES;
                  phase_in    = PH_EXTLEN;
               end else if (req_rx_byte[6:0] == LEN_EXT64) begin
                  ext_left_in = EXT64_BYTES;
                  phase_in    = PH_EXTLEN;
               end else begin
                  hdr_done = 1'b1;
                  hdr_len  = {57'd0, req_rx_byte[6:0]};
               end
            end
            PH_EXTLEN: begin
               remaining_in = ext_shift;
               ext_left_in  = ext_dec;
               if (ext_dec == '0) begin
                  hdr_done = 1'b1;
                  hdr_len  = ext_shift;
               end
            end
            PH_PAYLOAD: begin
               if (opcode_ff == OPC_BINARY) begin
                  cmd_push     = 1'b1;
                  cmd.is_pong  = 1'b0;
                  cmd.data     = req_rx_byte;
                  cmd.last     = (remaining_ff == 64'd1);
               end else if (opcode_ff == OPC_PING && count_ff < CW'(PONG_MAX)) begin
                  st_we    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               remaining_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_OPCODE;
                  if (opcode_ff == OPC_PING) begin
                     cmd_push    = 1'b1;
                     cmd.is_pong = 1'b1;
                     cmd.data    = 8'(count_in);
                     cmd.last    = 1'b0;
                  end
               end
            end
            default: begin
               opcode_in   = req_rx_byte[3:0];
               ext_left_in = '0;
               phase_in    = PH_LENGTH;
            end
         endcase
         if (hdr_done) begin
            count_in     = '0;
            remaining_in = hdr_len;
            if (hdr_len == '0) begin
               phase_in = PH_OPCODE;
               if (opcode_ff == OPC_PING) begin
                  cmd_push    = 1'b1;
                  cmd.is_pong = 1'b1;
                  cmd.data    = '0;
                  cmd.last    = 1'b0;
               end
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         opcode_ff    <= '0;
         remaining_ff <= '0;
         ext_left_ff  <= '0;
         count_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         opcode_ff    <= opcode_in;
         remaining_ff <= remaining_in;
         ext_left_ff  <= ext_left_in;
         count_ff     <= count_in;
      end
   end

   `ASSERT_SYNC(a_payload_nonzero, phase_ff == PH_PAYLOAD |-> remaining_ff != '0, "payload phase with nothing left")

endmodule

// ----- src/wsrx_back.sv -----
// Output sequencer: drains the command queue into the result register and
// expands each pong command into the header, key and captured payload.
// Depends on wsrx_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wsrx_back import wsrx_pkg::*; #(
   parameter int PONG_MAX = 16,
   localparam int AW = (PONG_MAX > 1) ? $clog2(PONG_MAX) : 1,
   localparam int CW = $clog2(PONG_MAX + 1),
   localparam int IW = $clog2(PONG_MAX + PONG_HDR_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_empty,
   input  cmd_type       cmd,
   output logic          cmd_pop,
   input  logic [31:0]   key,
   output logic          st_re,
   output logic [AW-1:0] st_addr,
   input  logic [7:0]    st_data,
   output logic          pong_done,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_out_kind,
   output logic          rsp_out_last
);

   back_state_type state_ff, state_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  n_ff, n_in;
   logic           valid_ff, valid_in;
   logic [7:0]     byte_ff, byte_in;
   logic           kind_ff, kind_in;
   logic           last_ff, last_in;
   logic           from_store_ff, from_store_in;

   logic           load_ok;
   logic [IW-1:0]  last_idx;
   logic [7:0]     hdr_byte;

   assign load_ok  = !valid_ff || rsp_pop;
   assign last_idx = IW'(n_ff) + IW'(PONG_HDR_BYTES - 1);

   always_comb begin
      case (idx_ff[2:0])
         3'd0:    hdr_byte = PONG_HEADER;
         3'd1:    hdr_byte = LEN_MASK_BIT | 8'(n_ff);
         3'd2:    hdr_byte = key[31:24];
         3'd3:    hdr_byte = key[23:16];
         3'd4:    hdr_byte = key[15:8];
         default: hdr_byte = key[7:0];
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      valid_in      = valid_ff && !rsp_pop;
      byte_in       = byte_ff;
      kind_in       = kind_ff;
      last_in       = last_ff;
      from_store_in = from_store_ff;
      cmd_pop       = 1'b0;
      st_re         = 1'b0;
      st_addr       = AW'(idx_ff - IW'(PONG_HDR_BYTES));
      pong_done     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && load_ok) begin
               cmd_pop       = 1'b1;
               valid_in      = 1'b1;
               from_store_in = 1'b0;
               if (cmd.is_pong) begin
                  kind_in  = KIND_PONG;
                  byte_in  = PONG_HEADER;
                  last_in  = 1'b0;
                  n_in     = cmd.data[CW-1:0];
                  idx_in   = IW'(1);
                  state_in = BK_PONG;
               end else begin
                  kind_in = KIND_BINARY;
                  byte_in = cmd.data;
                  last_in = cmd.last;
               end
            end
         end
         BK_PONG: begin
            if (load_ok) begin
               valid_in = 1'b1;
               kind_in  = KIND_PONG;
               last_in  = (idx_ff == last_idx);
               idx_in   = idx_ff + 1'b1;
               if (idx_ff < IW'(PONG_HDR_BYTES)) begin
                  byte_in       = hdr_byte;
                  from_store_in = 1'b0;
               end else begin
                  from_store_in = 1'b1;
                  st_re         = 1'b1;
               end
               if (idx_ff == last_idx) begin
                  state_in  = BK_IDLE;
                  pong_done = 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      n_ff          <= n_in;
      byte_ff       <= byte_in;
      kind_ff       <= kind_in;
      last_ff       <= last_in;
      from_store_ff <= from_store_in;
   end

   assign rsp_empty    = !valid_ff;
   assign rsp_out_byte = from_store_ff ? st_data : byte_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_last = last_ff;

   `ASSERT_SYNC(a_pong_ends, state_ff == BK_PONG && load_ok && idx_ff == last_idx |=> state_ff == BK_IDLE, "pong burst did not end")
   `ASSERT_SYNC(a_store_is_pong, valid_ff && from_store_ff |-> kind_ff == KIND_PONG, "store word outside a pong")

endmodule

// ----- src/websocket_rx_deframer_with_pong.sv -----
// Top level of the WebSocket receive deframer with automatic pong reply.
// Depends on wsrx_pkg, wsrx_front, wsrx_cmd_fifo, wsrx_back and wsrx_ram.
//
//   Channel   Ports                                   Direction
//   req       req_push, req_full, req_rx_byte         in  (queue write side)
//   rsp       rsp_pop, rsp_empty, rsp_out_byte/kind/last  out (queue read side)
//   csr       csr_valid, csr_ready, csr_masking_key   in  (write only)
//
// The parser takes one word per cycle unless stalled; each word is classified
// in that cycle. The output sequencer sends one word per cycle while popped.
// A ping frame stalls at its first word after the opcode while an earlier
// pong is still reading the pong store, and input stalls when the
// four-entry command queue is full. Reset is synchronous and needs no pass.
`include "assert_macros.svh"
module websocket_rx_deframer_with_pong import wsrx_pkg::*; #(
   parameter int PONG_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_kind,
   output logic        rsp_out_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_masking_key
);

   localparam int AW = (PONG_MAX > 1) ? $clog2(PONG_MAX) : 1;

   logic [31:0]   key_ff, key_in;
   logic          pong_busy_ff, pong_busy_in;

   logic          fifo_full, fifo_empty, fifo_pop;
   logic          cmd_push;
   cmd_type       cmd_in_word, cmd_head;
   logic          st_we, st_re;
   logic [AW-1:0] st_waddr, st_raddr;
   logic [7:0]    st_wdata, st_rdata;
   logic          pong_done;

   assign csr_ready = 1'b1;

   always_comb begin
      key_in       = (csr_valid && csr_ready) ? csr_masking_key : key_ff;
      pong_busy_in = pong_busy_ff;
      if (pong_done) begin
         pong_busy_in = 1'b0;
      end
      if (cmd_push && cmd_in_word.is_pong && !fifo_full) begin
         pong_busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         pong_busy_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         pong_busy_ff <= pong_busy_in;
      end
   end

   wsrx_front #(
      .PONG_MAX (PONG_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .fifo_full   (fifo_full),
      .pong_busy   (pong_busy_ff),
      .cmd_push    (cmd_push),
      .cmd         (cmd_in_word),
      .st_we       (st_we),
      .st_addr     (st_waddr),
      .st_data     (st_wdata)
   );

   wsrx_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in_word),
      .full     (fifo_full),
      .pop      (fifo_pop),
      .empty    (fifo_empty),
      .head     (cmd_head)
   );

   wsrx_ram #(
      .WIDTH (8),
      .DEPTH (PONG_MAX)
   ) u_pong_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   wsrx_back #(
      .PONG_MAX (PONG_MAX)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (fifo_empty),
      .cmd          (cmd_head),
      .cmd_pop      (fifo_pop),
      .key          (key_ff),
      .st_re        (st_re),
      .st_addr      (st_raddr),
      .st_data      (st_rdata),
      .pong_done    (pong_done),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_last (rsp_out_last)
   );

   `ASSERT_SYNC(a_no_store_clash, st_we |-> !pong_busy_ff, "pong store write during a pong")

endmodule

// ----- tb/tb_websocket_rx_deframer_with_pong.sv -----
// Testbench for websocket_rx_deframer_with_pong: a directed table and random WebSocket
// frames are pushed in, and every popped word is checked against an in-bench deframer model.
// Depends on wsrx_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb_websocket_rx_deframer_with_pong import wsrx_pkg::*;;

   localparam int PONG_MAX      = 16;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int IDLE_PCT      = 32;

   typedef struct packed {
      logic [7:0] data;
      logic       kind;
      logic       last;
   } out_word_type;

   typedef struct packed {
      logic [7:0]   rx;
      logic         typed;
      logic [4:0]   count;
      out_word_type first;
   } dir_row_type;

   localparam out_word_type NO_WORD = '0;
   localparam int DIR_ROWS = 27;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{8'h82, 1'b0, 5'd0, NO_WORD},
      '{8'h01, 1'b0, 5'd0, NO_WORD},
      '{8'hFF, 1'b1, 5'd1, {8'hFF, KIND_BINARY, 1'b1}},
      '{8'h02, 1'b0, 5'd0, NO_WORD},
      '{8'h80, 1'b1, 5'd0, NO_WORD},
      '{8'h89, 1'b0, 5'd0, NO_WORD},
      '{8'h80, 1'b1, 5'd6, {PONG_HEADER, KIND_PONG, 1'b0}},
      '{8'h89, 1'b0, 5'd0, NO_WORD},
      '{8'h7E, 1'b0, 5'd0, NO_WORD},
      '{8'h00, 1'b0, 5'd0, NO_WORD},
      '{8'h02, 1'b1, 5'd0, NO_WORD},
      '{8'h00, 1'b0, 5'd0, NO_WORD},
      '{8'h80, 1'b1, 5'd8, {PONG_HEADER, KIND_PONG, 1'b0}},
      '{8'h81, 1'b0, 5'd0, NO_WORD},
      '{8'h01, 1'b0, 5'd0, NO_WORD},
      '{8'hAA, 1'b1, 5'd0, NO_WORD},
      '{8'hF2, 1'b0, 5'd0, NO_WORD},
      '{8'hFF, 1'b0, 5'd0, NO_WORD},
      '{8'h00, 1'b0, 5'd0, NO_WORD},
      '{8'h00, 1'b0, 5'd0, NO_WORD},
      '{8'h00, 1'b0, 5'd0, NO_WORD},
      '{8'h00, 1'b0, 5'd0, NO_WORD},
      '{8'h00, 1'b0, 5'd0, NO_WORD},
      '{8'h00, 1'b0, 5'd0, NO_WORD},
      '{8'h00, 1'b0, 5'd0, NO_WORD},
      '{8'h01, 1'b0, 5'd0, NO_WORD},
      '{8'h00, 1'b1, 5'd1, {8'h00, KIND_BINARY, 1'b1}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_kind;
   logic        rsp_out_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_masking_key = '0;

   phase_type   ph = PH_OPCODE;
   logic [3:0]  opc = '0;
   logic [63:0] remaining = '0;
   logic [3:0]  ext_left = '0;
   logic [7:0]  echo_buf [PONG_MAX];
   int          echo_cnt = 0;
   logic [31:0] mask_key = '0;

   out_word_type pending_out [$];
   out_word_type step_words [$];
   logic [7:0]   stream_q [$];
   out_word_type want;
   int          mismatches = 0;
   int          table_errors = 0;
   int          stall_cycles = 0;
   bit          hold_req = 1'b0;
   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;

   websocket_rx_deframer_with_pong #(.PONG_MAX(PONG_MAX)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_rx_byte     (req_rx_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_last    (rsp_out_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_masking_key (csr_masking_key)
   );

   always #5 clock = ~clock;

   function automatic void queue_pong();
      step_words.push_back({PONG_HEADER, KIND_PONG, 1'b0});
      step_words.push_back({8'(echo_cnt) | LEN_MASK_BIT, KIND_PONG, 1'b0});
      step_words.push_back({mask_key[31:24], KIND_PONG, 1'b0});
      step_words.push_back({mask_key[23:16], KIND_PONG, 1'b0});
      step_words.push_back({mask_key[15:8], KIND_PONG, 1'b0});
      step_words.push_back({mask_key[7:0], KIND_PONG, 1'(echo_cnt == 0)});
      for (int i = 0; i < echo_cnt; i++) begin
         step_words.push_back({echo_buf[i], KIND_PONG, 1'(i == echo_cnt - 1)});
      end
      echo_cnt = 0;
   endfunction

   function automatic void finish_header();
      echo_cnt = 0;
      if (remaining == 0) begin
         ph = PH_OPCODE;
         if (opc == OPC_PING) queue_pong();
      end else begin
         ph = PH_PAYLOAD;
      end
   endfunction

   function automatic void deframe_word(input logic [7:0] b);
      logic [6:0] len;
      step_words.delete();
      case (ph)
         PH_LENGTH: begin
            len = b[6:0];
            remaining = '0;
            if (len == LEN_EXT16) begin
               ext_left = EXT16_BYTES;
               ph = PH_EXTLEN;
            end else if (len == LEN_EXT64) begin
               ext_left = EXT64_BYTES;
               ph = PH_EXTLEN;
            end else begin
               remaining = 64'(len);
               finish_header();
            end
         end
         PH_EXTLEN: begin
            remaining = {remaining[55:0], b};
            if (ext_left > 0) ext_left = ext_left - 1'b1;
            if (ext_left == 0) finish_header();
         end
         PH_PAYLOAD: begin
            if (opc == OPC_BINARY) begin
               step_words.push_back({b, KIND_BINARY, 1'(remaining == 1)});
            end else if (opc == OPC_PING && echo_cnt < PONG_MAX) begin
               echo_buf[echo_cnt] = b;
               echo_cnt++;
            end
            if (remaining > 0) remaining = remaining - 1;
            if (remaining == 0) begin
               ph = PH_OPCODE;
               if (opc == OPC_PING) queue_pong();
            end
         end
         default: begin
            opc = b[3:0];
            ext_left = '0;
            ph = PH_LENGTH;
         end
      endcase
      foreach (step_words[i]) pending_out.push_back(step_words[i]);
   endfunction

   task automatic send_word(input logic [7:0] b);
      @(negedge clock);
      while (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      deframe_word(b);
   endtask

   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mask_key(input logic [31:0] k);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_masking_key <= k;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mask_key = k;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_frame(input logic [7:0] head, input int unsigned len,
                            input int unsigned enc);
      logic [63:0] len64;
      logic        mask;
      len64 = 64'(len);
      mask = 1'($urandom_range(0, 1));
      stream_q.push_back(head);
      if (enc == 0) begin
         stream_q.push_back({mask, len64[6:0]});
      end else if (enc == 1) begin
         stream_q.push_back({mask, LEN_EXT16});
         stream_q.push_back(len64[15:8]);
         stream_q.push_back(len64[7:0]);
      end else begin
         stream_q.push_back({mask, LEN_EXT64});
         for (int k = 7; k >= 0; k--) stream_q.push_back(len64[8*k +: 8]);
      end
      for (int unsigned i = 0; i < len; i++) stream_q.push_back(8'($urandom));
   endtask

   // Mostly binary frames and pings, some of them longer than the pong store,
   // with the rest spread over the opcodes that the block skips.
   task automatic random_frame();
      int unsigned pick;
      int unsigned len;
      int unsigned enc;
      logic [3:0]  code;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         code = OPC_BINARY;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      end else if (pick < 75) begin
         code = OPC_PING;
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(PONG_MAX + 1, PONG_MAX + 24)
                                           : $urandom_range(0, PONG_MAX);
      end else begin
         do code = 4'($urandom_range(0, 15));
         while (code == OPC_BINARY || code == OPC_PING);
         len = $urandom_range(0, 20);
      end
      pick = $urandom_range(0, 9);
      enc = (pick < 7) ? 0 : (pick < 9) ? 1 : 2;
      add_frame({4'($urandom_range(0, 15)), code}, len, enc);
   endtask

   // A leading binary frame guarantees enough result words to back up the block.
   task automatic run_random(input int unsigned n_words, input bit lead_binary);
      logic [7:0] next_b;
      stream_q.delete();
      if (lead_binary) add_frame({4'h8, OPC_BINARY}, 12, 0);
      while (stream_q.size() < n_words) random_frame();
      while (stream_q.size() != 0) begin
         next_b = stream_q[0];
         stream_q.delete(0);
         send_word(next_b);
      end
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_pop <= !(receiver_idles && $urandom_range(0, 99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_out.size() == 0) begin
            $error("unexpected word: byte %h kind %b last %b",
                   rsp_out_byte, rsp_out_kind, rsp_out_last);
            mismatches++;
         end else begin
            want = pending_out[0];
            pending_out.delete(0);
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %h, got %h", want.data, rsp_out_byte);
               mismatches++;
            end
            if (rsp_out_kind !== want.kind) begin
               $error("out_kind: expected %b, got %b", want.kind, rsp_out_kind);
               mismatches++;
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %b, got %b", want.last, rsp_out_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         send_word(DIRECTED[r].rx);
         if (DIRECTED[r].typed) begin
            if (step_words.size() != int'(DIRECTED[r].count)) begin
               $error("word count at row %0d: expected %0d, got %0d",
                      r, DIRECTED[r].count, step_words.size());
               table_errors++;
            end else if (DIRECTED[r].count != 0 && step_words[0] != DIRECTED[r].first) begin
               $error("first word at row %0d: expected %h, got %h",
                      r, DIRECTED[r].first, step_words[0]);
               table_errors++;
            end
         end
      end
      settle();

      set_mask_key(32'hFFFF_FFFF);
      run_random(25, 1'b0);
      settle();

      // The receiver holds off while the sender keeps pushing, so the block backs up.
      set_mask_key($urandom);
      hold_req = 1'b1;
      sender_idles = 1'b0;
      run_random(35, 1'b1);
      sender_idles = 1'b1;
      settle();

      set_mask_key(32'h0000_0000);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      run_random(20, 1'b0);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      settle();

      set_mask_key($urandom);
      run_random(20, 1'b0);
      settle();

      if (mismatches == 0 && table_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
